### design/stpc_pkg.sv
// Package for the temperature/pressure compensation unit.
// Holds status codes, widths and compensation constants. No dependencies.
package stpc_pkg;

   localparam int RawWidth   = 20;
   localparam int ValueWidth = 24;
   localparam int WordWidth  = 64;
   localparam int CsrWidth   = 64;
   localparam int CsrIdxWidth = 2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FINE = 2'd1,
      STATUS_ZERO_DIV = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_CAL_T  = 2'd0,
      CSR_CAL_PA = 2'd1,
      CSR_CAL_PB = 2'd2,
      CSR_CAL_PC = 2'd3
   } csr_idx_type;

   typedef enum logic {
      OP_TEMP  = 1'b0,
      OP_PRESS = 1'b1
   } op_type;

   // Divider handshake between sequencer and divide unit
   typedef struct packed {
      logic                        start;
      logic signed [WordWidth-1:0] dividend;
      logic signed [WordWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [WordWidth-1:0] quotient;
   } div_rsp_type;

   localparam logic signed [WordWidth-1:0] FineOffset = 64'sd128000;
   localparam logic signed [WordWidth-1:0] PressBase  = 64'sd1048576;
   localparam logic signed [WordWidth-1:0] PressScale = 64'sd3125;

   // Saturate a 64-bit signed value to the output width
   function automatic logic signed [ValueWidth-1:0] sat24(input logic signed [WordWidth-1:0] x);
      logic signed [WordWidth-1:0] hi;
      logic signed [WordWidth-1:0] lo;
      hi = 64'sd8388607;
      lo = -64'sd8388608;
      if (x > hi) begin
         return hi[ValueWidth-1:0];
      end else if (x < lo) begin
         return lo[ValueWidth-1:0];
      end
      return x[ValueWidth-1:0];
   endfunction

endpackage

### design/stpc_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating.
// Depends on stpc_pkg.
module stpc_div
   import stpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CntWidth = $clog2(WordWidth + 1);

   logic                 busy_ff, busy_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] quo_ff, quo_in;
   logic [WordWidth-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;

   logic [WordWidth-1:0] abs_n;
   logic [WordWidth-1:0] abs_d;
   logic [WordWidth:0]   trial;
   logic [WordWidth-1:0] shifted;

   always_comb begin
      abs_n   = div_req.dividend[WordWidth-1] ? (~div_req.dividend + 1'b1)
                                              : div_req.dividend;
      abs_d   = div_req.divisor[WordWidth-1] ? (~div_req.divisor + 1'b1)
                                             : div_req.divisor;
      shifted = {rem_ff[WordWidth-2:0], quo_ff[WordWidth-1]};
      trial   = {rem_ff[WordWidth-1], shifted} - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // load magnitudes, remember sign of the quotient
         busy_in = 1'b1;
         cnt_in  = CntWidth'(WordWidth);
         rem_in  = '0;
         quo_in  = abs_n;
         den_in  = abs_d;
         neg_in  = div_req.dividend[WordWidth-1] ^ div_req.divisor[WordWidth-1];
      end else if (busy_ff) begin
         // restoring step: shift in next dividend bit
         if (!trial[WordWidth]) begin
            rem_in = trial[WordWidth-1:0];
            quo_in = {quo_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

### design/stpc_seq.sv
// Sequencer with one shared 32x32 multiplier that builds 64-bit wrapped
// products over three partial steps, plus add/shift. Depends on stpc_pkg, stpc_div.
module stpc_seq
   import stpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [47:0]                  cal_t,
   input  logic [WordWidth-1:0]         cal_pa,
   input  logic [WordWidth-1:0]         cal_pb,
   input  logic signed [15:0]           cal_pc,
   input  logic                         start,
   input  logic                         start_op,
   input  logic [RawWidth-1:0]          start_raw,
   output logic                         busy,
   output logic                         done,
   output logic signed [ValueWidth-1:0] done_value,
   output status_type                   done_status
);

   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
      S_PCHK, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
      S_DIV, S_DWAIT, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_FIN
   } state_type;

   typedef enum logic [1:0] {
      MP_LL, MP_LH, MP_HL, MP_DONE
   } mphase_type;

   state_type   state_ff, state_in;
   mphase_type  mph_ff, mph_in;
   logic [RawWidth-1:0] raw_ff;
   logic signed [31:0] fine_ff, fine_in;
   logic signed [WordWidth-1:0] x_ff, sq_ff, v1_ff, v2_ff, p_ff, q_ff, acc_ff;
   logic signed [WordWidth-1:0] x_in, sq_in, v1_in, v2_in, p_in, q_in, acc_in;
   logic signed [WordWidth-1:0] ma_ff, mb_ff, ma_in, mb_in;
   logic signed [WordWidth-1:0] prod_ff, prod_in;
   logic        done_ff, done_in;
   logic signed [ValueWidth-1:0] val_ff, val_in;
   status_type  stat_ff, stat_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        mul_go;
   logic signed [WordWidth-1:0] t1, t2, t3;
   logic signed [WordWidth-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [WordWidth-1:0] rawx;

   stpc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // Calibration slices
   always_comb begin
      t1 = 64'(cal_t[15:0]);
      t2 = 64'(signed'(cal_t[31:16]));
      t3 = 64'(signed'(cal_t[47:32]));
      p1 = 64'(cal_pa[15:0]);
      p2 = 64'(signed'(cal_pa[31:16]));
      p3 = 64'(signed'(cal_pa[47:32]));
      p4 = 64'(signed'(cal_pa[63:48]));
      p5 = 64'(signed'(cal_pb[15:0]));
      p6 = 64'(signed'(cal_pb[31:16]));
      p7 = 64'(signed'(cal_pb[47:32]));
      p8 = 64'(signed'(cal_pb[63:48]));
      p9 = 64'(cal_pc);
      rawx = 64'(raw_ff);
   end

   // Shared 32x32 unsigned multiplier; a 64-bit wrapped product is LL + (LH+HL)<<32
   always_comb begin
      case (mph_ff)
         MP_LL:   begin mul_a = ma_ff[31:0];  mul_b = mb_ff[31:0];  end
         MP_LH:   begin mul_a = ma_ff[31:0];  mul_b = mb_ff[63:32]; end
         MP_HL:   begin mul_a = ma_ff[63:32]; mul_b = mb_ff[31:0];  end
         default: begin mul_a = '0;           mul_b = '0;           end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      mph_in  = mph_ff;
      prod_in = prod_ff;
      if (mul_go) begin
         mph_in  = MP_LH;
         prod_in = '0;
      end else begin
         case (mph_ff)
            MP_LL: begin
               prod_in = prod_ff + signed'(mul_p);
               mph_in  = MP_LH;
            end
            MP_LH: begin
               prod_in = prod_ff + signed'({mul_p[31:0], 32'd0});
               mph_in  = MP_HL;
            end
            MP_HL: begin
               prod_in = prod_ff + signed'({mul_p[31:0], 32'd0});
               mph_in  = MP_DONE;
            end
            default: ;
         endcase
      end
   end

   // Main sequence: each multiply step issues operands then waits MP_DONE
   logic mul_ready;
   assign mul_ready = (mph_ff == MP_DONE);

   always_comb begin
      state_in = state_ff;
      fine_in  = fine_ff;
      x_in = x_ff; sq_in = sq_ff; v1_in = v1_ff; v2_in = v2_ff;
      p_in = p_ff; q_in = q_ff; acc_in = acc_ff;
      ma_in = ma_ff; mb_in = mb_ff;
      mul_go = 1'b0;
      done_in = 1'b0;
      val_in = val_ff;
      stat_in = stat_ff;
      div_req.start    = 1'b0;
      div_req.dividend = p_ff;
      div_req.divisor  = v1_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (start_op == OP_TEMP) ? S_T0 : S_PCHK;
            end
         end
         // a = ((raw>>3) - 2*t1) * t2
         S_T0: begin
            ma_in = (rawx >>> 3) - (t1 <<< 1);
            mb_in = t2;
            mul_go = 1'b1;
            state_in = S_T1;
         end
         S_T1: if (mul_ready) begin
            acc_in = prod_ff >>> 11;
            x_in   = (rawx >>> 4) - t1;
            ma_in  = (rawx >>> 4) - t1;
            mb_in  = (rawx >>> 4) - t1;
            mul_go = 1'b1;
            state_in = S_T2;
         end
         S_T2: if (mul_ready) begin
            ma_in = prod_ff >>> 12;
            mb_in = t3;
            mul_go = 1'b1;
            state_in = S_T3;
         end
         S_T3: if (mul_ready) begin
            acc_in = acc_ff + (prod_ff >>> 14);
            state_in = S_T4;
         end
         S_T4: begin
            fine_in = acc_ff[31:0];
            p_in = ((acc_ff * 5) + 64'sd128) >>> 8;
            state_in = S_T5;
         end
         S_T5: begin
            val_in  = sat24(p_ff * 10);
            stat_in = STATUS_OK;
            state_in = S_FIN;
         end
         S_PCHK: begin
            if (fine_ff == 0) begin
               val_in  = '0;
               stat_in = STATUS_NO_FINE;
               state_in = S_FIN;
            end else begin
               x_in  = 64'(fine_ff) - FineOffset;
               ma_in = 64'(fine_ff) - FineOffset;
               mb_in = 64'(fine_ff) - FineOffset;
               mul_go = 1'b1;
               state_in = S_P0;
            end
         end
         S_P0: if (mul_ready) begin   // sq = x*x
            sq_in = prod_ff;
            ma_in = prod_ff; mb_in = p6; mul_go = 1'b1;
            state_in = S_P1;
         end
         S_P1: if (mul_ready) begin   // v2 = sq*p6
            v2_in = prod_ff;
            ma_in = x_ff; mb_in = p5; mul_go = 1'b1;
            state_in = S_P2;
         end
         S_P2: if (mul_ready) begin   // v2 += (x*p5)<<17 + p4<<35
            v2_in = v2_ff + (prod_ff <<< 17) + (p4 <<< 35);
            ma_in = sq_ff; mb_in = p3; mul_go = 1'b1;
            state_in = S_P3;
         end
         S_P3: if (mul_ready) begin   // v1 = (sq*p3)>>8
            v1_in = prod_ff >>> 8;
            ma_in = x_ff; mb_in = p2; mul_go = 1'b1;
            state_in = S_P4;
         end
         S_P4: if (mul_ready) begin   // v1 += (x*p2)<<12 plus 1<<47, then *p1
            ma_in = (64'sd1 <<< 47) + v1_ff + (prod_ff <<< 12);
            mb_in = p1; mul_go = 1'b1;
            state_in = S_P5;
         end
         S_P5: if (mul_ready) begin
            v1_in = prod_ff >>> 33;
            state_in = S_P6;
         end
         S_P6: begin
            if (v1_ff == 0) begin
               val_in  = '0;
               stat_in = STATUS_ZERO_DIV;
               state_in = S_FIN;
            end else begin
               ma_in = ((PressBase - rawx) <<< 31) - v2_ff;
               mb_in = PressScale; mul_go = 1'b1;
               state_in = S_P7;
            end
         end
         S_P7: if (mul_ready) begin
            p_in = prod_ff;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_req.start = 1'b1;
            state_in = S_DWAIT;
         end
         S_DWAIT: if (div_rsp.done) begin
            p_in = div_rsp.quotient;
            q_in = div_rsp.quotient >>> 13;
            ma_in = p9; mb_in = div_rsp.quotient >>> 13; mul_go = 1'b1;
            state_in = S_Q0;
         end
         S_Q0: if (mul_ready) begin   // (p9*q)*q
            ma_in = prod_ff; mb_in = q_ff; mul_go = 1'b1;
            state_in = S_Q1;
         end
         S_Q1: if (mul_ready) begin
            v1_in = prod_ff >>> 25;
            ma_in = p8; mb_in = p_ff; mul_go = 1'b1;
            state_in = S_Q2;
         end
         S_Q2: if (mul_ready) begin
            v2_in = prod_ff >>> 19;
            state_in = S_Q3;
         end
         S_Q3: begin
            acc_in = ((p_ff + v1_ff + v2_ff) >>> 8) + (p7 <<< 4);
            state_in = S_Q4;
         end
         S_Q4: begin
            val_in  = sat24(acc_ff >>> 8);
            stat_in = STATUS_OK;
            state_in = S_FIN;
         end
         S_FIN: begin
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mph_ff   <= MP_DONE;
         fine_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mph_ff   <= mul_go ? MP_LL : mph_in;
         fine_ff  <= fine_in;
         done_ff  <= done_in;
      end
      if (start && state_ff == S_IDLE) begin
         raw_ff <= start_raw;
      end
      prod_ff <= mul_go ? '0 : prod_in;
      x_ff <= x_in; sq_ff <= sq_in; v1_ff <= v1_in; v2_ff <= v2_in;
      p_ff <= p_in; q_ff <= q_in; acc_ff <= acc_in;
      ma_ff <= ma_in; mb_ff <= mb_in;
      val_ff <= val_in;
      stat_ff <= stat_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign done        = done_ff;
   assign done_value  = val_ff;
   assign done_status = stat_ff;

endmodule

### design/sensor_temp_pressure_compensation_unit.sv
// Temperature/pressure compensation top level: calibration registers,
// input/output beat handshake, around stpc_seq. Depends on stpc_pkg, stpc_seq.
// Results: temperature, pressure, or early exits for no fine temperature and zero divisor;
// the work is paced by the shared multiplier passes and the bit-serial divider.
// Throughput: one item at a time; next beat taken the cycle after the result beat.
// Reset: synchronous; clears calibration registers, fine temperature, sequencer state and result valid.
module sensor_temp_pressure_compensation_unit
   import stpc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [CsrWidth-1:0]          csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [RawWidth-1:0]          req_raw_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ValueWidth-1:0] rsp_value,
   output logic [1:0]                   rsp_status
);

   logic [47:0]          cal_t_ff;
   logic [WordWidth-1:0] cal_pa_ff, cal_pb_ff;
   logic signed [15:0]   cal_pc_ff;
   logic                 rsp_valid_ff;
   logic signed [ValueWidth-1:0] rsp_value_ff;
   status_type           rsp_status_ff;
   logic                 seq_busy, seq_done;
   logic signed [ValueWidth-1:0] seq_value;
   status_type           seq_status;
   logic                 take;

   // Accept a beat only when the sequencer is idle and the output slot is free
   assign req_stall = seq_busy || seq_done || rsp_valid_ff;
   assign take      = req_valid && !req_stall;

   stpc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cal_t      (cal_t_ff),
      .cal_pa     (cal_pa_ff),
      .cal_pb     (cal_pb_ff),
      .cal_pc     (cal_pc_ff),
      .start      (take),
      .start_op   (req_op),
      .start_raw  (req_raw_sample),
      .busy       (seq_busy),
      .done       (seq_done),
      .done_value (seq_value),
      .done_status(seq_status)
   );

   // Calibration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_pa_ff <= '0;
         cal_pb_ff <= '0;
         cal_pc_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAL_T:  cal_t_ff  <= csr_data[47:0];
            CSR_CAL_PA: cal_pa_ff <= csr_data;
            CSR_CAL_PB: cal_pb_ff <= csr_data;
            CSR_CAL_PC: cal_pc_ff <= signed'(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_done) begin
         rsp_value_ff  <= seq_value;
         rsp_status_ff <= seq_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### test/tb_top.sv
// Testbench for the temperature/pressure compensation unit: directed rows, then random beats
// under three idle mixes, checked against an in-bench compensation predictor.
// Depends on stpc_pkg and sensor_temp_pressure_compensation_unit.
`timescale 1ns / 100ps

module tb_top;
   import stpc_pkg::*;

   localparam int WatchdogLimit = 6000;
   localparam int DrainCycles   = 150;
   localparam int RandomPerSet  = 110;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      status_type            status;
   } reading_type;

   typedef struct {
      int                  cal_set;
      op_type              op;
      logic [RawWidth-1:0] raw;
      bit                  typed;
      logic [23:0]         value;
      status_type          status;
   } plan_row_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_write;
   logic [CsrIdxWidth-1:0]       csr_index;
   logic [CsrWidth-1:0]          csr_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_op;
   logic [RawWidth-1:0]          req_raw_sample;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [ValueWidth-1:0] rsp_value;
   logic [1:0]                   rsp_status;

   // Predictor copy of calibration and fine temperature
   logic [47:0] cal_t;
   logic [63:0] cal_pa;
   logic [63:0] cal_pb;
   logic [15:0] cal_pc;
   logic [31:0] fine_temp;

   reading_type expected_readings[$];
   int          error_count;
   int          beats_in;
   int          beats_out;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles;
   int          status_seen[3];

   sensor_temp_pressure_compensation_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_raw_sample (req_raw_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp24(input longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
   endfunction

   // Compensate one sample; a temperature sample updates the fine temperature
   function automatic reading_type compensate(input op_type op, input logic [RawWidth-1:0] raw);
      reading_type res;
      longint r, t1, t2, t3, a, d, b, tf;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, x, sq, v1, v2, p, q;
      r = longint'({44'd0, raw});
      res.value = '0;
      res.status = STATUS_OK;
      if (op == OP_TEMP) begin
         t1 = longint'({48'd0, cal_t[15:0]});
         t2 = longint'($signed(cal_t[31:16]));
         t3 = longint'($signed(cal_t[47:32]));
         a = (((r >>> 3) - (t1 <<< 1)) * t2) >>> 11;
         d = (r >>> 4) - t1;
         b = (((d * d) >>> 12) * t3) >>> 14;
         tf = a + b;
         fine_temp = tf[31:0];
         res.value = ValueWidth'(clamp24(((tf * 5 + 128) >>> 8) * 10));
      end else if (fine_temp == 0) begin
         res.status = STATUS_NO_FINE;
      end else begin
         p1 = longint'({48'd0, cal_pa[15:0]});
         p2 = longint'($signed(cal_pa[31:16]));
         p3 = longint'($signed(cal_pa[47:32]));
         p4 = longint'($signed(cal_pa[63:48]));
         p5 = longint'($signed(cal_pb[15:0]));
         p6 = longint'($signed(cal_pb[31:16]));
         p7 = longint'($signed(cal_pb[47:32]));
         p8 = longint'($signed(cal_pb[63:48]));
         p9 = longint'($signed(cal_pc));
         x = longint'($signed(fine_temp)) - 128000;
         sq = x * x;
         v2 = sq * p6 + ((x * p5) <<< 17) + (p4 <<< 35);
         v1 = ((sq * p3) >>> 8) + ((x * p2) <<< 12);
         v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            res.status = STATUS_ZERO_DIV;
         end else begin
            p = 1048576 - r;
            p = ((p <<< 31) - v2) * 3125;
            // most negative over minus one wraps to itself
            if (!(p == 64'sh8000_0000_0000_0000 && v1 == -1)) p = p / v1;
            q = p >>> 13;
            v1 = ((p9 * q) * q) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            res.value = ValueWidth'(clamp24(p >>> 8));
         end
      end
      return res;
   endfunction

   task automatic write_csr(input csr_idx_type idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_CAL_T:  cal_t  = data[47:0];
         CSR_CAL_PA: cal_pa = data;
         CSR_CAL_PB: cal_pb = data;
         default:    cal_pc = data[15:0];
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait for the block to drain before touching calibration
   task automatic wait_idle();
      wait (expected_readings.size() == 0);
      @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_cal(input logic [47:0] t, input logic [63:0] pa, input logic [63:0] pb,
                           input logic [15:0] pc);
      wait_idle();
      write_csr(CSR_CAL_T, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | t);
      write_csr(CSR_CAL_PA, pa);
      write_csr(CSR_CAL_PB, pb);
      write_csr(CSR_CAL_PC, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | pc);
      cal_t = t;
   endtask

   // Drive one beat; called and returns at a falling edge
   task automatic send_sample(input op_type op, input logic [RawWidth-1:0] raw, input bit typed,
                              input logic [23:0] value, input status_type status);
      reading_type pred;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_op <= 1'($urandom);
         req_raw_sample <= RawWidth'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_raw_sample <= raw;
      do @(posedge clock); while (req_stall);
      pred = compensate(op, raw);
      if (typed) begin
         pred.value = value;
         pred.status = status;
      end
      expected_readings.push_back(pred);
      beats_in++;
      @(negedge clock);
   endtask

   // Receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (expected_readings.size() == 0) begin
            $error("result beat with nothing expected: value=%0d status=%0d", rsp_value, rsp_status);
            error_count++;
         end else begin
            exp_r = expected_readings.pop_front();
            if (rsp_value !== exp_r.value) begin
               $error("value: expected %0d actual %0d", $signed(exp_r.value), rsp_value);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_status < 3) status_seen[rsp_status]++;
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   localparam logic [47:0] TypT  = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TypPA = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
   localparam logic [63:0] TypPB = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
   localparam logic [15:0] TypPC = 16'd6000;

   plan_row_type plan[] = '{
      // reset calibration: no fine temperature, then a temperature of exactly zero
      '{0, OP_PRESS, 20'd415148,  1, 24'd0, STATUS_NO_FINE},
      '{0, OP_TEMP,  20'd0,       1, 24'd0, STATUS_OK},
      '{0, OP_TEMP,  20'hFFFFF,   1, 24'd0, STATUS_OK},
      '{0, OP_PRESS, 20'hFFFFF,   1, 24'd0, STATUS_NO_FINE},
      '{0, OP_PRESS, 20'd0,       1, 24'd0, STATUS_NO_FINE},
      // typical calibration
      '{1, OP_PRESS, 20'd415148,  1, 24'd0, STATUS_NO_FINE},
      '{1, OP_TEMP,  20'd519888,  0, 24'd0, STATUS_OK},
      '{1, OP_PRESS, 20'd415148,  0, 24'd0, STATUS_OK},
      '{1, OP_PRESS, 20'd0,       0, 24'd0, STATUS_OK},
      '{1, OP_PRESS, 20'hFFFFF,   0, 24'd0, STATUS_OK},
      '{1, OP_TEMP,  20'd0,       0, 24'd0, STATUS_OK},
      '{1, OP_PRESS, 20'd300000,  0, 24'd0, STATUS_OK},
      '{1, OP_TEMP,  20'hFFFFF,   0, 24'd0, STATUS_OK},
      '{1, OP_PRESS, 20'h80000,   0, 24'd0, STATUS_OK},
      '{1, OP_TEMP,  20'd519888,  0, 24'd0, STATUS_OK},
      // P1 of zero forces a zero divisor
      '{2, OP_PRESS, 20'd415148,  1, 24'd0, STATUS_ZERO_DIV},
      '{2, OP_PRESS, 20'hFFFFF,   1, 24'd0, STATUS_ZERO_DIV},
      '{2, OP_TEMP,  20'd600000,  0, 24'd0, STATUS_OK},
      '{2, OP_PRESS, 20'd0,       1, 24'd0, STATUS_ZERO_DIV},
      // extreme calibration words
      '{3, OP_TEMP,  20'hFFFFF,   0, 24'd0, STATUS_OK},
      '{3, OP_PRESS, 20'd0,       0, 24'd0, STATUS_OK},
      '{3, OP_TEMP,  20'd0,       0, 24'd0, STATUS_OK},
      '{3, OP_PRESS, 20'hFFFFF,   0, 24'd0, STATUS_OK},
      '{4, OP_TEMP,  20'h55555,   0, 24'd0, STATUS_OK},
      '{4, OP_PRESS, 20'hAAAAA,   0, 24'd0, STATUS_OK}
   };

   task automatic apply_cal_set(input int set_id);
      case (set_id)
         1: load_cal(TypT, TypPA, TypPB, TypPC);
         2: load_cal(TypT, {TypPA[63:16], 16'd0}, TypPB, TypPC);
         3: load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     16'h8000);
         4: load_cal(48'h8000_7FFF_FFFF, 64'h7FFF_8000_7FFF_FFFF, 64'h8000_7FFF_8000_7FFF,
                     16'h7FFF);
         default: ;
      endcase
   endtask

   // Random calibration: typical, jittered typical, fully random words, jittered with zero P1, or an extreme set
   task automatic random_cal(input int kind);
      logic [63:0] ja;
      logic [63:0] jb;
      logic [47:0] jt;
      jt = TypT ^ {16'($urandom_range(255)), 16'($urandom_range(255)),
                   16'($urandom_range(255))};
      ja = TypPA ^ {16'($urandom_range(255)), 16'($urandom_range(255)),
                    16'($urandom_range(255)), 16'($urandom_range(255))};
      jb = TypPB ^ {16'($urandom_range(63)), 16'($urandom_range(255)),
                    16'($urandom_range(255)), 16'($urandom_range(15))};
      case (kind)
         0: load_cal(TypT, TypPA, TypPB, TypPC);
         1: load_cal(jt, ja, jb, TypPC ^ 16'($urandom_range(4095)));
         2: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom));
         3: load_cal(jt, {ja[63:16], 16'd0}, jb, 16'($urandom));
         default: apply_cal_set(3 + $urandom_range(1));
      endcase
   endtask

   function automatic logic [RawWidth-1:0] pick_raw();
      case ($urandom_range(9))
         0: return 20'd0;
         1: return 20'hFFFFF;
         2, 3, 4: return 20'($urandom_range(650000, 250000));
         default: return 20'($urandom);
      endcase
   endfunction

   initial begin
      int cur_set;
      op_type op;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_CAL_T;
      csr_data = '0;
      req_valid = 1'b0;
      req_op = OP_TEMP;
      req_raw_sample = '0;
      rsp_stall = 1'b0;
      cal_t = '0;
      cal_pa = '0;
      cal_pb = '0;
      cal_pc = '0;
      fine_temp = '0;
      error_count = 0;
      beats_in = 0;
      beats_out = 0;
      quiet_cycles = 0;
      status_seen = '{0, 0, 0};
      idle_pct = 36;
      stall_pct = 65;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows
      cur_set = 0;
      foreach (plan[i]) begin
         if (plan[i].cal_set != cur_set) begin
            req_valid <= 1'b0;
            cur_set = plan[i].cal_set;
            apply_cal_set(cur_set);
         end
         send_sample(plan[i].op, plan[i].raw, plan[i].typed, plan[i].value, plan[i].status);
      end

      // Random beats under three idle mixes
      for (int mode = 0; mode < 3; mode++) begin
         idle_pct  = (mode == 0) ? 36 : (mode == 1) ? 65 : 0;
         stall_pct = (mode == 0) ? 65 : (mode == 1) ? 36 : 0;
         for (int kind = 0; kind < 5; kind++) begin
            req_valid <= 1'b0;
            random_cal(kind);
            // hold a fine temperature first so pressure beats get past the guard
            send_sample(OP_TEMP, 20'($urandom_range(650000, 400000)), 0, '0, STATUS_OK);
            for (int n = 0; n < RandomPerSet; n++) begin
               op = ($urandom_range(99) < 60) ? OP_PRESS : OP_TEMP;
               send_sample(op, pick_raw(), 0, '0, STATUS_OK);
            end
         end
      end
      req_valid <= 1'b0;

      wait (expected_readings.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("Covered %0d sample beats, %0d result beats (ok %0d, no fine %0d, zero div %0d)",
               beats_in, beats_out, status_seen[0], status_seen[1], status_seen[2]);
      $display("over zero, typical, extreme and random calibration under three idle mixes");
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
design/stpc_pkg.sv
design/stpc_div.sv
design/stpc_seq.sv
design/sensor_temp_pressure_compensation_unit.sv
test/tb_top.sv
